FILE: rtl/dc_median_dpcm_assert.svh
// ----------------------------------------------------------------------------
// dc_median_dpcm_assert.svh
// Assertion macros for the DC median DPCM block. The bodies are empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DC_MEDIAN_DPCM_ASSERT_SVH
`define DC_MEDIAN_DPCM_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and an active-low reset.
`define DCMD_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dc_median_dpcm: assertion failed");
// Shorthand on the block's own clock and reset.
`define DCMD_ASSERT(lbl, prop) \
  `DCMD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define DCMD_ASSERT_CLK(lbl, clk, rst_n, prop)
`define DCMD_ASSERT(lbl, prop)
`endif

`endif

FILE: rtl/dcmd_pkg.sv
// ----------------------------------------------------------------------------
// dcmd_pkg
// Widths, register indexes and the prediction mode for the DC median DPCM.
// ----------------------------------------------------------------------------
package dcmd_pkg;

  localparam int DC_W       = 12;
  localparam int RES_W      = DC_W + 1;
  localparam int NUM_COMP   = 3;
  localparam int LS_W       = NUM_COMP * DC_W;
  localparam int MAX_BPR    = 256;
  localparam int MAX_ROWS   = 4096;
  localparam int COL_W      = $clog2(MAX_BPR);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int BPR_W      = 9;
  localparam int ROWS_W     = 13;
  localparam int CFG_W      = ROWS_W;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_TDATA_W  = ((NUM_COMP * DC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_COMP * RES_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS     = 1'd1;

  typedef enum logic [1:0] {
    PRED_RAW,
    PRED_LEFT,
    PRED_UP,
    PRED_MEDIAN
  } pred_mode_e;

endpackage

FILE: rtl/dc_median_dpcm.sv
// ----------------------------------------------------------------------------
// dc_median_dpcm
// DPCM of block DC triples with left / upper / median prediction and a line
// store holding the previous block row.
// ----------------------------------------------------------------------------
//  channel  dir  signals                    contents
//  s_axis   in   tvalid tready tdata[39:0]  y_dc, cb_dc, cr_dc
//  m_axis   out  tvalid tready tdata[39:0]  y/cb/cr residual; tlast = end_of_frame
//  cfg      in   we idx data[12:0]          0: blocks_per_row, 1: block_rows
//
// One block per cycle while the output is not stalled; an input beat goes into the
// lane stage (line store read), then lane arithmetic feeds the output register.
// No clearing pass after reset: the line store is written before it is read.
// Input ready drops only while both the lane stage and the output register
// are full and the output is stalled.
// ----------------------------------------------------------------------------
`include "dc_median_dpcm_assert.svh"

module dc_median_dpcm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // y_dc[11:0], cb_dc[23:12], cr_dc[35:24], zero pad
  input  logic [dcmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // y_residual[12:0], cb_residual[25:13], cr_residual[38:26], zero pad
  output logic [dcmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [dcmd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dcmd_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int DC_W  = dcmd_pkg::DC_W;
  localparam int RES_W = dcmd_pkg::RES_W;
  localparam int NC    = dcmd_pkg::NUM_COMP;
  localparam int OUT_PAD = dcmd_pkg::OUT_TDATA_W - NC * RES_W;

  // configuration
  logic [dcmd_pkg::BPR_W-1:0]  bpr_q;
  logic [dcmd_pkg::ROWS_W-1:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q  <= dcmd_pkg::BPR_W'(1);
      rows_q <= dcmd_pkg::ROWS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcmd_pkg::REG_BLOCKS_PER_ROW: bpr_q  <= cfg_data_i[dcmd_pkg::BPR_W-1:0];
        dcmd_pkg::REG_BLOCK_ROWS:     rows_q <= cfg_data_i[dcmd_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // last column / row index, counts clamped to their legal range
  logic [dcmd_pkg::COL_W-1:0] col_last;
  logic [dcmd_pkg::ROW_W-1:0] row_last;

  always_comb begin
    if (bpr_q == '0)
      col_last = '0;
    else if (bpr_q > dcmd_pkg::BPR_W'(dcmd_pkg::MAX_BPR))
      col_last = dcmd_pkg::COL_W'(dcmd_pkg::MAX_BPR - 1);
    else
      col_last = dcmd_pkg::COL_W'(bpr_q - 1'b1);

    if (rows_q == '0)
      row_last = '0;
    else if (rows_q > dcmd_pkg::ROWS_W'(dcmd_pkg::MAX_ROWS))
      row_last = dcmd_pkg::ROW_W'(dcmd_pkg::MAX_ROWS - 1);
    else
      row_last = dcmd_pkg::ROW_W'(rows_q - 1'b1);
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // block position
  logic [dcmd_pkg::COL_W-1:0] col_q, col_d;
  logic [dcmd_pkg::ROW_W-1:0] row_q, row_d;
  logic is_last_col, is_last_row;

  assign is_last_col = col_q >= col_last;
  assign is_last_row = row_q >= row_last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (is_last_col) begin
        col_d = '0;
        row_d = is_last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  dcmd_pkg::pred_mode_e mode;

  always_comb begin
    if (row_q == '0)
      mode = (col_q == '0) ? dcmd_pkg::PRED_RAW : dcmd_pkg::PRED_LEFT;
    else
      mode = (col_q == '0) ? dcmd_pkg::PRED_UP : dcmd_pkg::PRED_MEDIAN;
  end

  // line store, read and written on every input beat
  logic [dcmd_pkg::LS_W-1:0] cur_in, upper;

  assign cur_in = s_axis_tdata[dcmd_pkg::LS_W-1:0];

  dcmd_line_store u_line_store (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .addr_i  (col_q),
    .wdata_i (cur_in),
    .rdata_o (upper)
  );

  // lane stage registers
  logic [dcmd_pkg::LS_W-1:0] left_q;
  logic [dcmd_pkg::LS_W-1:0] s1_cur_q, s1_left_q, s1_ul_q;
  dcmd_pkg::pred_mode_e      s1_mode_q;
  logic                      s1_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_mode_q  <= dcmd_pkg::PRED_RAW;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        left_q    <= cur_in;
        s1_mode_q <= mode;
      end
    end
  end

  // upper of the previous block is still in the read register at this beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cur_q  <= cur_in;
      s1_left_q <= left_q;
      s1_ul_q   <= upper;
      s1_eof_q  <= is_last_col && is_last_row;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)      s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  // lanes
  logic [NC*RES_W-1:0] res;

  for (genvar k = 0; k < NC; k++) begin : g_lane
    dcmd_lane u_lane (
      .mode_i       (s1_mode_q),
      .cur_i        (s1_cur_q[k*DC_W +: DC_W]),
      .left_i       (s1_left_q[k*DC_W +: DC_W]),
      .upper_i      (upper[k*DC_W +: DC_W]),
      .upper_left_i (s1_ul_q[k*DC_W +: DC_W]),
      .res_o        (res[k*RES_W +: RES_W])
    );
  end

  // merge into the output register
  logic [NC*RES_W-1:0] out_res_q;
  logic                out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv)             out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q  <= res;
      out_last_q <= s1_eof_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_res_q};
  assign m_axis_tlast  = out_last_q;

  `DCMD_ASSERT(a_ready_low_means_full, !s_axis_tready |-> s1_valid_q && out_valid_q)
  `DCMD_ASSERT(a_stalled_stage_holds, s1_valid_q && !s1_adv |=> s1_valid_q)
  `DCMD_ASSERT(a_col_wraps, in_acc && is_last_col |=> col_q == '0)
  `DCMD_ASSERT(a_col_steps, in_acc && !is_last_col |=> col_q == $past(col_q) + 1'b1)
  `DCMD_ASSERT(a_pos_idle_hold, !in_acc |=> $stable(col_q) && $stable(row_q))

endmodule

FILE: rtl/dcmd_line_store.sv
// ----------------------------------------------------------------------------
// dcmd_line_store
// One block row of raw DC triples. Read and write share the address; the
// registered read returns the entry as it was before the write.
// ----------------------------------------------------------------------------
module dcmd_line_store (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dcmd_pkg::COL_W-1:0]  addr_i,
  input  logic [dcmd_pkg::LS_W-1:0]   wdata_i,
  output logic [dcmd_pkg::LS_W-1:0]   rdata_o
);

  logic [dcmd_pkg::LS_W-1:0] mem [dcmd_pkg::MAX_BPR];
  logic [dcmd_pkg::LS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem[addr_i] <= wdata_i;
      rdata_q     <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dcmd_lane.sv
// ----------------------------------------------------------------------------
// dcmd_lane
// One colour component: picks the prediction (none, left, upper or median of
// left, upper and upper-left) and forms the residual.
// ----------------------------------------------------------------------------
module dcmd_lane (
  input  dcmd_pkg::pred_mode_e               mode_i,
  input  logic signed [dcmd_pkg::DC_W-1:0]   cur_i,
  input  logic signed [dcmd_pkg::DC_W-1:0]   left_i,
  input  logic signed [dcmd_pkg::DC_W-1:0]   upper_i,
  input  logic signed [dcmd_pkg::DC_W-1:0]   upper_left_i,
  output logic signed [dcmd_pkg::RES_W-1:0]  res_o
);

  function automatic logic signed [dcmd_pkg::DC_W-1:0] median3(
    input logic signed [dcmd_pkg::DC_W-1:0] a,
    input logic signed [dcmd_pkg::DC_W-1:0] b,
    input logic signed [dcmd_pkg::DC_W-1:0] c
  );
    logic signed [dcmd_pkg::DC_W-1:0] m;
    if (a > b) begin
      if (a > c) m = (c > b) ? c : b;
      else       m = a;
    end else begin
      if (a > c) m = a;
      else       m = (b > c) ? c : b;
    end
    return m;
  endfunction

  logic signed [dcmd_pkg::DC_W-1:0] pred;

  always_comb begin
    case (mode_i)
      dcmd_pkg::PRED_RAW:    pred = '0;
      dcmd_pkg::PRED_LEFT:   pred = left_i;
      dcmd_pkg::PRED_UP:     pred = upper_i;
      dcmd_pkg::PRED_MEDIAN: pred = median3(left_i, upper_i, upper_left_i);
      default:               pred = '0;
    endcase
  end

  assign res_o = dcmd_pkg::RES_W'(cur_i) - dcmd_pkg::RES_W'(pred);

endmodule
